/* rtl/core/lbt_pkg.sv */
// Shared types and constants of the lossless byte tokenizer.
package lbt_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned OUT_OFS_W  = 32;
  localparam int unsigned SRC_W      = 16;
  localparam int unsigned COND_W     = 64;
  localparam int unsigned REC_SLOTS  = 3;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATION_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONDITION_WORD   = 2'd2;

  // Record type codes
  localparam logic REC_TOKEN    = 1'b0;
  localparam logic REC_TRAILING = 1'b1;

  // Byte classes
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_TAB        = 8'h09;
  localparam logic [7:0] CHAR_CR         = 8'h0D;
  localparam logic [7:0] CHAR_DIGIT_LO   = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_HI   = 8'h39;
  localparam logic [7:0] CHAR_UPPER_LO   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_HI   = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_LO   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_HI   = 8'h7A;

  // One record as carried from front to back
  typedef struct packed {
    logic                 rtype;
    logic [OUT_OFS_W-1:0] trivia;
    logic [OUT_OFS_W-1:0] token;
    logic [OUT_OFS_W-1:0] end_ofs;
    logic                 active;
    logic                 ovf;
  } rec_t;

  // All records caused by one byte; cnt is 0 to 3, and only batches with records are pushed
  typedef struct packed {
    logic [1:0]                cnt;
    rec_t [REC_SLOTS-1:0]      recs;
  } batch_t;

  function automatic logic is_word_byte(logic [7:0] c);
    return (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) ||
           (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) ||
           (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) ||
           (c == CHAR_UNDERSCORE);
  endfunction

  function automatic logic is_space_byte(logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

endpackage

/* rtl/core/lbt_if.sv */
// Channel interfaces of the lossless byte tokenizer: text in, records out, config write.
interface lbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface lbt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          record_type;
  logic [lbt_pkg::OUT_OFS_W-1:0] trivia_offset;
  logic [lbt_pkg::OUT_OFS_W-1:0] token_offset;
  logic [lbt_pkg::OUT_OFS_W-1:0] end_offset;
  logic [lbt_pkg::SRC_W-1:0]     span_source;
  logic                          is_active;
  logic [lbt_pkg::COND_W-1:0]    condition_tag;
  logic                          offset_overflow;
  logic                          last_of_run;

  modport source (output valid, output record_type, output trivia_offset,
                  output token_offset, output end_offset, output span_source,
                  output is_active, output condition_tag, output offset_overflow,
                  output last_of_run, input ready);
  modport sink   (input valid, input record_type, input trivia_offset,
                  input token_offset, input end_offset, input span_source,
                  input is_active, input condition_tag, input offset_overflow,
                  input last_of_run, output ready);
endinterface

interface lbt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lbt_pkg::CFG_IDX_W-1:0]  index;
  logic [lbt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/lossless_byte_tokenizer.sv */
// Top level of the lossless byte tokenizer: config registers, front, queue and back.
//
// The tokenizer takes source text one byte per transaction and reports spans:
// every token record carries where its leading trivia starts, where the token
// starts and one past its end, the source id, an active flag and the condition
// word; the byte flagged end_of_text closes any open word and adds a trailing
// trivia record. A byte is accepted every cycle as long as the two-entry batch
// queue has room. Each byte yields zero to three records, and the output
// register sends one record per cycle while the receiver is ready, so the
// records of a byte take the output in turn: the output port sets the sustained rate, one
// byte per cycle while bytes average at most one record. Word and whitespace bytes that
// close nothing yield no record and cost the output nothing. Records of one
// byte leave in order, the last one marked with last_of_run. Offsets count
// OFFSET_BITS wide, saturate at their top value (offset_overflow then set for
// the rest of the source) and are shown in the low 32 bits. Write the config
// registers only while no records are pending; there is no clearing pass.
module lossless_byte_tokenizer #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbt_in_if.sink      in_i,
  lbt_out_if.source   out_o,
  lbt_cfg_if.sink     cfg_i
);

  logic [lbt_pkg::SRC_W-1:0]     source_id_q;
  logic [lbt_pkg::OUT_OFS_W-1:0] act_start_q;
  logic [lbt_pkg::COND_W-1:0]    cond_word_q;

  logic            push;
  lbt_pkg::batch_t batch;
  logic            queue_ready;
  logic            head_valid;
  lbt_pkg::batch_t head;
  logic            pop;

  // Config writes are always taken; an index past the list is dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_id_q <= '0;
      act_start_q <= '0;
      cond_word_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        lbt_pkg::CFG_SOURCE_ID:        source_id_q <= cfg_i.data[lbt_pkg::SRC_W-1:0];
        lbt_pkg::CFG_ACTIVATION_START: act_start_q <= cfg_i.data[lbt_pkg::OUT_OFS_W-1:0];
        lbt_pkg::CFG_CONDITION_WORD:   cond_word_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Front: classify the byte and build the batch of records it causes
  lbt_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .act_start_i   (act_start_q),
    .push_o        (push),
    .batch_o       (batch),
    .queue_ready_i (queue_ready)
  );

  // Queue: decouple byte intake from record output
  lbt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .batch_i      (batch),
    .ready_o      (queue_ready),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Back: serialize records onto the output register
  lbt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .source_id_i  (source_id_q),
    .condition_i  (cond_word_q),
    .out_o        (out_o)
  );

endmodule

/* rtl/core/lbt_front.sv */
// Front end: classify each byte, track word and trivia state, build record batches.
module lbt_front #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lbt_in_if.sink                        in_i,
  input  logic [lbt_pkg::OUT_OFS_W-1:0] act_start_i,
  output logic                          push_o,
  output lbt_pkg::batch_t               batch_o,
  input  logic                          queue_ready_i
);

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] OFFSET_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] triv_q, triv_d;
  logic [OFFSET_BITS-1:0] ws_q, ws_d;
  logic                   inside_q, inside_d;
  logic                   sat_q, sat_d;
  logic                   accept;

  function automatic logic [lbt_pkg::OUT_OFS_W-1:0] low_ofs(logic [OFFSET_BITS-1:0] x);
    logic [63:0] wide;
    wide = 64'(x);
    return wide[lbt_pkg::OUT_OFS_W-1:0];
  endfunction

  function automatic lbt_pkg::rec_t mk_rec(logic rtype, logic [OFFSET_BITS-1:0] triv,
                                           logic [OFFSET_BITS-1:0] tok,
                                           logic [OFFSET_BITS-1:0] end_ofs,
                                           logic [lbt_pkg::OUT_OFS_W-1:0] act,
                                           logic ovf);
    lbt_pkg::rec_t r;
    r.rtype   = rtype;
    r.trivia  = low_ofs(triv);
    r.token   = low_ofs(tok);
    r.end_ofs = low_ofs(end_ofs);
    r.active  = (rtype == lbt_pkg::REC_TOKEN) && (64'(tok) >= 64'(act));
    r.ovf     = ovf;
    return r;
  endfunction

  assign in_i.ready = queue_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    logic [OFFSET_BITS-1:0] nxt;
    logic                   sat_now;
    logic [1:0]             n;
    n         = 2'd0;
    sat_now   = sat_q || (pos_q == OFFSET_MAX);
    nxt       = (pos_q == OFFSET_MAX) ? OFFSET_MAX : pos_q + OFFSET_ONE;
    triv_d    = triv_q;
    ws_d      = ws_q;
    inside_d  = inside_q;
    pos_d     = nxt;
    sat_d     = sat_now;
    batch_o   = '0;

    if (lbt_pkg::is_word_byte(in_i.text_byte)) begin
      if (!inside_d) begin
        inside_d = 1'b1;
        ws_d     = pos_q;
      end
    end else begin
      // close an open word at this byte
      if (inside_d) begin
        batch_o.recs[n] = mk_rec(lbt_pkg::REC_TOKEN, triv_d, ws_d, pos_q,
                                 act_start_i, sat_now);
        n        = n + 2'd1;
        inside_d = 1'b0;
        triv_d   = pos_q;
      end
      if (!lbt_pkg::is_space_byte(in_i.text_byte)) begin
        batch_o.recs[n] = mk_rec(lbt_pkg::REC_TOKEN, triv_d, pos_q, nxt,
                                 act_start_i, sat_now);
        n      = n + 2'd1;
        triv_d = nxt;
      end
    end

    if (in_i.end_of_text) begin
      if (inside_d) begin
        batch_o.recs[n] = mk_rec(lbt_pkg::REC_TOKEN, triv_d, ws_d, nxt,
                                 act_start_i, sat_now);
        n      = n + 2'd1;
        triv_d = nxt;
      end
      batch_o.recs[n] = mk_rec(lbt_pkg::REC_TRAILING, triv_d, nxt, nxt,
                               act_start_i, sat_now);
      n        = n + 2'd1;
      // start the next source from offset zero
      pos_d    = '0;
      inside_d = 1'b0;
      triv_d   = '0;
      ws_d     = '0;
      sat_d    = 1'b0;
    end

    batch_o.cnt = n;
  end

  assign push_o = accept && (batch_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      triv_q   <= '0;
      ws_q     <= '0;
      inside_q <= 1'b0;
      sat_q    <= 1'b0;
    end else if (accept) begin
      pos_q    <= pos_d;
      triv_q   <= triv_d;
      ws_q     <= ws_d;
      inside_q <= inside_d;
      sat_q    <= sat_d;
    end
  end

endmodule

/* rtl/core/lbt_queue.sv */
// Two-entry queue of record batches between front and back.
module lbt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lbt_pkg::batch_t batch_i,
  output logic            ready_o,
  output logic            head_valid_o,
  output lbt_pkg::batch_t head_o,
  input  logic            pop_i
);

  lbt_pkg::batch_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;

  assign ready_o      = (count_q != 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= batch_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/core/lbt_back.sv */
// Back end: walk the records of the head batch onto the registered output channel.
module lbt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  lbt_pkg::batch_t               head_i,
  output logic                          pop_o,
  input  logic [lbt_pkg::SRC_W-1:0]     source_id_i,
  input  logic [lbt_pkg::COND_W-1:0]    condition_i,
  lbt_out_if.source                     out_o
);

  logic          valid_q, valid_d;
  logic [1:0]    idx_q, idx_d;
  logic          load;
  logic          last;
  lbt_pkg::rec_t sel;

  logic                          rtype_q;
  logic [lbt_pkg::OUT_OFS_W-1:0] triv_q, tok_q, end_q;
  logic [lbt_pkg::SRC_W-1:0]     src_q;
  logic                          active_q, ovf_q, last_q;
  logic [lbt_pkg::COND_W-1:0]    cond_q;

  assign sel   = head_i.recs[idx_q];
  assign last  = (idx_q == head_i.cnt - 2'd1);
  assign load  = head_valid_i && (!valid_q || out_o.ready);
  assign pop_o = load && last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = last ? 2'd0 : idx_q + 2'd1;
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rtype_q  <= sel.rtype;
      triv_q   <= sel.trivia;
      tok_q    <= sel.token;
      end_q    <= sel.end_ofs;
      src_q    <= source_id_i;
      active_q <= sel.active;
      cond_q   <= (sel.rtype == lbt_pkg::REC_TOKEN) ? condition_i : '0;
      ovf_q    <= sel.ovf;
      last_q   <= last;
    end
  end

  assign out_o.valid           = valid_q;
  assign out_o.record_type     = rtype_q;
  assign out_o.trivia_offset   = triv_q;
  assign out_o.token_offset    = tok_q;
  assign out_o.end_offset      = end_q;
  assign out_o.span_source     = src_q;
  assign out_o.is_active       = active_q;
  assign out_o.condition_tag   = cond_q;
  assign out_o.offset_overflow = ovf_q;
  assign out_o.last_of_run     = last_q;

endmodule

/* rtl/core/lbt_checker.sv */
// Port-level assertions of the lossless byte tokenizer and their bind.
module lbt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          record_type,
  input logic [lbt_pkg::OUT_OFS_W-1:0] trivia_offset,
  input logic [lbt_pkg::OUT_OFS_W-1:0] token_offset,
  input logic [lbt_pkg::OUT_OFS_W-1:0] end_offset,
  input logic                          is_active,
  input logic [lbt_pkg::COND_W-1:0]    condition_tag,
  input logic                          last_of_run
);

  // A stalled record holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(token_offset) &&
      $stable(trivia_offset) && $stable(end_offset) && $stable(record_type))
    else $error("output record changed while stalled");

  // The trailing record always closes the run of its byte
  a_trail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && record_type == lbt_pkg::REC_TRAILING |-> last_of_run)
    else $error("trailing record not marked last of run");

  // The trailing record is an empty span with no tag
  a_trail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && record_type == lbt_pkg::REC_TRAILING |->
      token_offset == end_offset && !is_active && condition_tag == '0)
    else $error("trailing record fields malformed");

  // No record shows during reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("output valid during reset");

endmodule

bind lossless_byte_tokenizer lbt_checker u_lbt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .record_type   (out_o.record_type),
  .trivia_offset (out_o.trivia_offset),
  .token_offset  (out_o.token_offset),
  .end_offset    (out_o.end_offset),
  .is_active     (out_o.is_active),
  .condition_tag (out_o.condition_tag),
  .last_of_run   (out_o.last_of_run)
);
